FILE: rtl/core/ias_pkg.sv
// Shared types for the indexed array store: command codes, result status
// codes and controller states. No dependencies.
`default_nettype none

package ias_pkg;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned POS_BITS    = 6;
  localparam int unsigned DATA_BITS   = 32;
  localparam int unsigned FILL_BITS   = 7;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_POP    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_POPRD,
    ST_SHIFT,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/indexed_array_store.sv
// Indexed array store: bounded ordered array of words in one synchronous RAM.
// Depends on ias_pkg for command, status and state types.
//
// One command word in, one result word out. Append, write, unused codes and
// every flagged command (full, index out of range, empty) finish in the cycle
// they are accepted, so they sustain one word per cycle while the output is
// not stalled. A read passes through the registered RAM read port and the
// RDWAIT state before its word is loaded. Remove closes the gap by moving each
// later entry down one place, one entry per cycle through the single read and
// single write port of the RAM; when the last entry is removed it finishes in
// the cycle it is accepted. Pop reads the front entry and then moves all
// remaining entries down the same way. The next command is taken only once
// the output register is empty or hands its word on at the same edge. The RAM
// needs no clearing after reset: only entries below the count are ever read.
`default_nettype none

module indexed_array_store
  import ias_pkg::*;
#(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [CMD_BITS-1:0]    cmd_i,
  input  wire logic [POS_BITS-1:0]    position_i,
  input  wire logic [DATA_BITS-1:0]   word_in_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [DATA_BITS-1:0]        word_out_o,
  output logic [FILL_BITS-1:0]        fill_o,
  output logic [STATUS_BITS-1:0]      status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Width wide enough to compare an index against the count.
  localparam int unsigned XW = (CW > POS_BITS) ? CW : POS_BITS;

  // Storage and its registered read port.
  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        rd_addr;

  state_e               st_q, st_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        cursor_q, cursor_d;
  logic [DATA_BITS-1:0] res_word_q, res_word_d;

  logic                 out_valid_q;
  logic [DATA_BITS-1:0] out_word_q;
  logic [FILL_BITS-1:0] out_fill_q;
  status_e              out_status_q;

  logic                 out_load;
  logic [DATA_BITS-1:0] out_word_d;
  status_e              out_status_d;

  logic                 slot_free;
  logic                 in_accept;
  logic                 pos_ok;
  logic                 pos_has_tail;
  logic [CW-1:0]        nxt;

  assign slot_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o   = !((st_q == ST_IDLE) && slot_free);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign pos_ok       = XW'(position_i) < XW'(count_q);
  // Entries sit above the removed index, so they have to move down.
  assign pos_has_tail = (XW'(position_i) + XW'(1)) < XW'(count_q);
  assign nxt          = CW'(cursor_q) + CW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    st_d         = st_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    res_word_d   = res_word_q;
    mem_we       = 1'b0;
    mem_waddr    = cursor_q;
    mem_wdata    = rdata_q;
    rd_addr      = '0;
    out_load     = 1'b0;
    out_word_d   = '0;
    out_status_d = STAT_OK;

    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd_e'(cmd_i))
            CMD_APPEND: begin
              out_load = 1'b1;
              if (count_q == CW'(DEPTH)) begin
                out_status_d = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_q);
                mem_wdata = WORD_BITS'(word_in_i);
                count_d   = count_q + CW'(1);
              end
            end
            CMD_REMOVE: begin
              if (!pos_ok) begin
                out_load     = 1'b1;
                out_status_d = STAT_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                if (pos_has_tail) begin
                  rd_addr  = AW'(position_i) + AW'(1);
                  cursor_d = AW'(position_i);
                  st_d     = ST_SHIFT;
                end else begin
                  out_load = 1'b1;
                end
              end
            end
            CMD_READ: begin
              if (!pos_ok) begin
                out_load     = 1'b1;
                out_status_d = STAT_RANGE;
              end else begin
                rd_addr = AW'(position_i);
                st_d    = ST_RDWAIT;
              end
            end
            CMD_WRITE: begin
              out_load = 1'b1;
              if (!pos_ok) begin
                out_status_d = STAT_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(position_i);
                mem_wdata = WORD_BITS'(word_in_i);
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                out_load     = 1'b1;
                out_status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CW'(1);
                rd_addr = '0;
                st_d    = ST_POPRD;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end

      ST_RDWAIT: begin
        res_word_d = DATA_BITS'(rdata_q);
        if (slot_free) begin
          out_load   = 1'b1;
          out_word_d = DATA_BITS'(rdata_q);
          st_d       = ST_IDLE;
        end else begin
          st_d = ST_RESP;
        end
      end

      ST_POPRD: begin
        // Hold the front word; the count already excludes it.
        res_word_d = DATA_BITS'(rdata_q);
        if (count_q != '0) begin
          rd_addr  = AW'(1);
          cursor_d = '0;
          st_d     = ST_SHIFT;
        end else if (slot_free) begin
          out_load   = 1'b1;
          out_word_d = DATA_BITS'(rdata_q);
          st_d       = ST_IDLE;
        end else begin
          st_d = ST_RESP;
        end
      end

      ST_SHIFT: begin
        // Move one entry down, fetch the one after it.
        mem_we    = 1'b1;
        mem_waddr = cursor_q;
        mem_wdata = rdata_q;
        if (nxt < count_q) begin
          rd_addr  = AW'(nxt + CW'(1));
          cursor_d = AW'(nxt);
        end else begin
          st_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_word_d = res_word_q;
          st_d       = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cursor_q <= cursor_d;
    // Remove reports a zero word; clear the held word when a command starts.
    if (in_accept) begin
      res_word_q <= '0;
    end else begin
      res_word_q <= res_word_d;
    end
    if (out_load) begin
      out_word_q   <= out_word_d;
      out_fill_q   <= FILL_BITS'(count_d);
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_out_o  = out_word_q;
  assign fill_o      = out_fill_q;
  assign status_o    = out_status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_count_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(count_q))
    else $error("entry count changed without a command");

  a_shift_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SHIFT) |-> (CW'(cursor_q) < count_q))
    else $error("entry move outside the held entries");

  a_late_result_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (st_q != ST_IDLE)) |-> (out_status_d == STAT_OK))
    else $error("flagged result issued after the accept cycle");

endmodule

`default_nettype wire
